### design/mrdc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Multi-ring drain package
// Shared widths, request codes and the request and response types of the
// shared arithmetic unit.
// ----------------------------------------------------------------------------
package mrdc_pkg;

  // Default configuration of the rings.
  localparam int DEF_RING_DEPTH = 4096;
  localparam int DEF_NUM_RINGS  = 8;

  // Fixed field widths.
  localparam int FUNC_W  = 3;
  localparam int CNT_W   = 16;
  localparam int SEL_W   = 3;
  localparam int POS_W   = 12;
  localparam int RING_W  = 3;
  localparam int START_W = 12;
  localparam int LEN_W   = 13;
  localparam int MASK_W  = 8;

  // The shared unit is wide enough for the ring depth itself (up to 2^16).
  localparam int ALU_W = 17;

  // Request function codes.
  localparam logic [FUNC_W-1:0] FUNC_COLLECT = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_RELEASE = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_RESET   = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_UPDATE  = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_QUERY   = 3'd4;

  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_e;

  typedef struct packed {
    alu_op_e            op;
    logic [ALU_W-1:0]   a;
    logic [ALU_W-1:0]   b;
  } alu_req_t;

  typedef struct packed {
    logic [ALU_W-1:0]   res;
    logic               carry;  // carry out on add, borrow on subtract
  } alu_rsp_t;

endpackage

### design/mrdc_alu.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Multi-ring drain shared arithmetic unit
// One add/subtract unit with carry (or borrow) out, used for every pointer
// difference, count comparison and sum of the sequencer.
// ----------------------------------------------------------------------------
module mrdc_alu (
  input  mrdc_pkg::alu_req_t req_i,
  output mrdc_pkg::alu_rsp_t rsp_o
);
  import mrdc_pkg::*;

  logic [ALU_W:0] sum;

  // A single adder; subtraction through the two's complement of b.
  always_comb begin
    unique case (req_i.op)
      ALU_ADD: sum = {1'b0, req_i.a} + {1'b0, req_i.b};
      ALU_SUB: sum = {1'b0, req_i.a} - {1'b0, req_i.b};
      default: sum = '0;
    endcase
  end

  assign rsp_o.res   = sum[ALU_W-1:0];
  assign rsp_o.carry = sum[ALU_W];

endmodule

### design/multi_ring_drain_with_commit_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Multi-ring drain with commit
// Keeps read, write and pending-read pointers for a set of circular event
// rings and serves collect, release, reset, producer update and query
// requests through a small sequencer around one shared add/subtract unit.
//
//  Channel  | Signals                                         | Direction
//  ---------+-------------------------------------------------+----------
//  request  | in_valid_i/in_ready_o, func, count, ring, pos   | in
//  result   | out_valid_o/out_ready_i, ring, start, len, tot  | out
//  config   | cfg_we_i, cfg_wdata_i (online mask)             | in
//
// One request is worked on at a time; in_ready_o is high only when idle.
// Collect checks each online ring's fill and, for a ring that gives data,
// forms the remaining count, the amount taken, the new total and any wrap
// split in turn, as every step shares the one adder. Results sit in an
// output register, so a stalled consumer only holds the sequencer when a
// second result waits.
// Reset clears all pointers at once through valid bits; no clearing pass.
// RING_DEPTH must be a power of two.
// ----------------------------------------------------------------------------
module multi_ring_drain_with_commit_top #(
  parameter int RING_DEPTH = mrdc_pkg::DEF_RING_DEPTH,
  parameter int NUM_RINGS  = mrdc_pkg::DEF_NUM_RINGS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Configuration
  input  logic                          cfg_we_i,
  input  logic [mrdc_pkg::MASK_W-1:0]   cfg_wdata_i,
  // Request channel
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [mrdc_pkg::FUNC_W-1:0]   func_i,
  input  logic [mrdc_pkg::CNT_W-1:0]    requested_count_i,
  input  logic [mrdc_pkg::SEL_W-1:0]    ring_select_i,
  input  logic [mrdc_pkg::POS_W-1:0]    write_position_i,
  // Result channel
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [mrdc_pkg::RING_W-1:0]   ring_index_o,
  output logic [mrdc_pkg::START_W-1:0]  seg_start_o,
  output logic [mrdc_pkg::LEN_W-1:0]    seg_len_o,
  output logic [mrdc_pkg::CNT_W-1:0]    total_count_o,
  output logic                          last_o
);
  import mrdc_pkg::*;

  localparam int PTR_W = $clog2(RING_DEPTH);
  localparam int RW    = (NUM_RINGS > 1) ? $clog2(NUM_RINGS) : 1;
  localparam logic [RW-1:0] RING_LAST = RW'(NUM_RINGS - 1);

  typedef enum logic [4:0] {
    S_IDLE,
    C_CHK,
    C_FILL,
    C_REM,
    C_MIN,
    C_COLL,
    C_END,
    C_CMP,
    C_SEG1,
    C_SEG2,
    C_PEND,
    Q_CHK,
    Q_FILL,
    Q_ADD,
    R_CHK,
    R_WR,
    S_FIN
  } state_e;

  state_e                state_q;
  logic [MASK_W-1:0]     online_mask_q;
  logic [RW-1:0]         ring_q;
  logic [CNT_W-1:0]      req_q;
  logic [CNT_W-1:0]      acc_q;
  logic [CNT_W-1:0]      rem_q;
  logic [CNT_W-1:0]      used_q;
  logic [PTR_W-1:0]      fill_q;
  logic [PTR_W:0]        at_end_q;
  logic                  wrap_q;
  logic                  two_q;
  logic [LEN_W-1:0]      len1_q;
  logic [LEN_W-1:0]      len2_q;
  logic [RING_W-1:0]     fin_ring_q;

  // Valid bits stand in for the zero reset of the pointer stores.
  logic [NUM_RINGS-1:0]  r_vld_q;
  logic [NUM_RINGS-1:0]  w_vld_q;
  logic [NUM_RINGS-1:0]  pend_mask_q;
  logic [NUM_RINGS-1:0]  online_vec;

  // Pointer stores with registered reads at the ring under work.
  logic [PTR_W-1:0]      read_mem [NUM_RINGS];
  logic [PTR_W-1:0]      write_mem [NUM_RINGS];
  logic [PTR_W-1:0]      pend_mem [NUM_RINGS];
  logic [PTR_W-1:0]      rd_r_q;
  logic [PTR_W-1:0]      rd_w_q;
  logic [PTR_W-1:0]      rd_p_q;
  logic                  rd_rv_q;
  logic                  rd_wv_q;
  logic [PTR_W-1:0]      r_val;
  logic [PTR_W-1:0]      w_val;

  // Held segment, released once the next one (or the end) is known.
  logic                  hold_vld_q;
  logic [RING_W-1:0]     hold_ring_q;
  logic [START_W-1:0]    hold_start_q;
  logic [LEN_W-1:0]      hold_len_q;
  logic [CNT_W-1:0]      hold_total_q;

  // Output register.
  logic                  out_vld_q;
  logic [RING_W-1:0]     out_ring_q;
  logic [START_W-1:0]    out_start_q;
  logic [LEN_W-1:0]      out_len_q;
  logic [CNT_W-1:0]      out_total_q;
  logic                  out_last_q;

  logic                  accept;
  logic                  out_free;
  logic                  out_load;
  logic                  can_stage;
  logic                  ring_end;
  logic                  sel_ok;
  logic [RW-1:0]         sel_idx;
  logic                  rd_we;
  logic                  wr_we;
  logic                  pd_we;
  alu_req_t              alu_req;
  alu_rsp_t              alu_rsp;

  // Rings without a mask bit count as offline.
  for (genvar g = 0; g < NUM_RINGS; g++) begin : g_online
    if (g < MASK_W) begin : g_masked
      assign online_vec[g] = online_mask_q[g];
    end else begin : g_off
      assign online_vec[g] = 1'b0;
    end
  end

  assign accept    = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == S_IDLE);
  assign out_free  = !out_vld_q || out_ready_i;
  assign can_stage = !hold_vld_q || out_free;
  assign ring_end  = (ring_q == RING_LAST);
  assign sel_ok    = (int'(ring_select_i) < NUM_RINGS);
  assign sel_idx   = RW'(ring_select_i);
  assign r_val     = rd_rv_q ? rd_r_q : '0;
  assign w_val     = rd_wv_q ? rd_w_q : '0;

  // A result enters the output register when a held segment moves on or
  // when the final result of a request is formed.
  assign out_load = (((state_q == C_SEG1) || (state_q == C_SEG2)) && can_stage && hold_vld_q) ||
                    ((state_q == S_FIN) && out_free);

  assign rd_we = (state_q == R_WR);
  assign wr_we = accept && (func_i == FUNC_UPDATE) && sel_ok;
  assign pd_we = (state_q == C_PEND);

  // Read pointer store: written on release commit.
  always_ff @(posedge clk_i) begin
    if (rd_we) begin
      read_mem[ring_q] <= rd_p_q;
    end
    rd_r_q <= read_mem[ring_q];
  end

  // Write pointer store: written by producer updates, wrapped to the depth.
  always_ff @(posedge clk_i) begin
    if (wr_we) begin
      write_mem[sel_idx] <= PTR_W'(write_position_i);
    end
    rd_w_q <= write_mem[ring_q];
  end

  // Pending pointer store: written at the end of each drained ring.
  always_ff @(posedge clk_i) begin
    if (pd_we) begin
      pend_mem[ring_q] <= alu_rsp.res[PTR_W-1:0];
    end
    rd_p_q <= pend_mem[ring_q];
  end

  // Operand selection for the shared unit.
  always_comb begin
    alu_req.op = ALU_SUB;
    alu_req.a  = '0;
    alu_req.b  = '0;
    unique case (state_q)
      C_CHK: begin
        alu_req.a = ALU_W'(acc_q);
        alu_req.b = ALU_W'(req_q);
      end
      C_FILL, Q_FILL: begin
        alu_req.a = ALU_W'(w_val);
        alu_req.b = ALU_W'(r_val);
      end
      C_REM: begin
        alu_req.a = ALU_W'(req_q);
        alu_req.b = ALU_W'(acc_q);
      end
      C_MIN: begin
        alu_req.a = ALU_W'(rem_q);
        alu_req.b = ALU_W'(fill_q);
      end
      C_COLL: begin
        alu_req.op = ALU_ADD;
        alu_req.a  = ALU_W'(acc_q);
        alu_req.b  = ALU_W'(used_q);
      end
      C_END: begin
        alu_req.a = ALU_W'(RING_DEPTH);
        alu_req.b = ALU_W'(r_val);
      end
      C_CMP: begin
        alu_req.a = ALU_W'(used_q);
        alu_req.b = ALU_W'(at_end_q);
      end
      C_PEND: begin
        alu_req.op = ALU_ADD;
        alu_req.a  = ALU_W'(r_val);
        alu_req.b  = ALU_W'(used_q);
      end
      Q_ADD: begin
        alu_req.op = ALU_ADD;
        alu_req.a  = ALU_W'(acc_q);
        alu_req.b  = ALU_W'(fill_q);
      end
      default: begin
        alu_req.op = ALU_SUB;
      end
    endcase
  end

  mrdc_alu u_alu (
    .req_i (alu_req),
    .rsp_o (alu_rsp)
  );

  // Read valid bits follow the registered store reads.
  always_ff @(posedge clk_i) begin
    rd_rv_q <= r_vld_q[ring_q];
    rd_wv_q <= w_vld_q[ring_q];
  end

  // Sequencer, pointer valid bits, held segment and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      online_mask_q <= '1;
      ring_q        <= '0;
      req_q         <= '0;
      acc_q         <= '0;
      r_vld_q       <= '0;
      w_vld_q       <= '0;
      pend_mask_q   <= '0;
      hold_vld_q    <= 1'b0;
      out_vld_q     <= 1'b0;
      fin_ring_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        online_mask_q <= cfg_wdata_i;
      end
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            ring_q     <= '0;
            acc_q      <= '0;
            req_q      <= requested_count_i;
            fin_ring_q <= (func_i == FUNC_UPDATE) ? RING_W'(ring_select_i) : '0;
            unique case (func_i)
              FUNC_COLLECT: state_q <= C_CHK;
              FUNC_RELEASE: state_q <= R_CHK;
              FUNC_RESET: begin
                r_vld_q     <= '0;
                w_vld_q     <= '0;
                pend_mask_q <= '0;
                state_q     <= S_FIN;
              end
              FUNC_UPDATE: begin
                if (sel_ok) begin
                  w_vld_q[sel_idx] <= 1'b1;
                end
                state_q <= S_FIN;
              end
              FUNC_QUERY: state_q <= Q_CHK;
              default:    state_q <= S_IDLE;
            endcase
          end
        end

        // Collect: skip offline rings, stop once the count is met.
        C_CHK: begin
          if (!online_vec[ring_q]) begin
            if (ring_end) begin
              state_q <= S_FIN;
            end else begin
              ring_q <= ring_q + 1'b1;
            end
          end else if (!alu_rsp.carry) begin
            state_q <= S_FIN;
          end else begin
            state_q <= C_FILL;
          end
        end

        C_FILL: begin
          fill_q <= alu_rsp.res[PTR_W-1:0];
          wrap_q <= alu_rsp.carry;
          if (alu_rsp.res[PTR_W-1:0] == '0) begin
            if (ring_end) begin
              state_q <= S_FIN;
            end else begin
              ring_q  <= ring_q + 1'b1;
              state_q <= C_CHK;
            end
          end else begin
            state_q <= C_REM;
          end
        end

        C_REM: begin
          rem_q   <= alu_rsp.res[CNT_W-1:0];
          state_q <= C_MIN;
        end

        // Take the smaller of the remaining count and the fill.
        C_MIN: begin
          used_q  <= alu_rsp.carry ? rem_q : CNT_W'(fill_q);
          state_q <= C_COLL;
        end

        C_COLL: begin
          acc_q   <= alu_rsp.res[CNT_W-1:0];
          len1_q  <= LEN_W'(used_q);
          two_q   <= 1'b0;
          state_q <= wrap_q ? C_END : C_SEG1;
        end

        C_END: begin
          at_end_q <= alu_rsp.res[PTR_W:0];
          state_q  <= C_CMP;
        end

        // Wrapped data: split when the used count runs past the end.
        C_CMP: begin
          if (!alu_rsp.carry && (alu_rsp.res != '0)) begin
            len1_q <= LEN_W'(at_end_q);
            len2_q <= LEN_W'(alu_rsp.res);
            two_q  <= 1'b1;
          end
          state_q <= C_SEG1;
        end

        C_SEG1: begin
          if (can_stage) begin
            if (hold_vld_q) begin
              out_ring_q  <= hold_ring_q;
              out_start_q <= hold_start_q;
              out_len_q   <= hold_len_q;
              out_total_q <= hold_total_q;
              out_last_q  <= 1'b0;
            end
            hold_vld_q   <= 1'b1;
            hold_ring_q  <= RING_W'(ring_q);
            hold_start_q <= START_W'(r_val);
            hold_len_q   <= len1_q;
            hold_total_q <= acc_q;
            state_q      <= two_q ? C_SEG2 : C_PEND;
          end
        end

        C_SEG2: begin
          if (can_stage) begin
            if (hold_vld_q) begin
              out_ring_q  <= hold_ring_q;
              out_start_q <= hold_start_q;
              out_len_q   <= hold_len_q;
              out_total_q <= hold_total_q;
              out_last_q  <= 1'b0;
            end
            hold_vld_q   <= 1'b1;
            hold_ring_q  <= RING_W'(ring_q);
            hold_start_q <= '0;
            hold_len_q   <= len2_q;
            hold_total_q <= acc_q;
            state_q      <= C_PEND;
          end
        end

        // The pending pointer is written to its store in the same cycle.
        C_PEND: begin
          pend_mask_q[ring_q] <= 1'b1;
          if (ring_end) begin
            state_q <= S_FIN;
          end else begin
            ring_q  <= ring_q + 1'b1;
            state_q <= C_CHK;
          end
        end

        // Query: sum the fill of the online rings.
        Q_CHK: begin
          if (online_vec[ring_q]) begin
            state_q <= Q_FILL;
          end else if (ring_end) begin
            state_q <= S_FIN;
          end else begin
            ring_q <= ring_q + 1'b1;
          end
        end

        Q_FILL: begin
          fill_q  <= alu_rsp.res[PTR_W-1:0];
          state_q <= Q_ADD;
        end

        // Saturate at each step; the sum only grows.
        Q_ADD: begin
          acc_q <= alu_rsp.res[CNT_W] ? '1 : alu_rsp.res[CNT_W-1:0];
          if (ring_end) begin
            state_q <= S_FIN;
          end else begin
            ring_q  <= ring_q + 1'b1;
            state_q <= Q_CHK;
          end
        end

        // Release: commit every pending pointer.
        R_CHK: begin
          if (pend_mask_q[ring_q]) begin
            state_q <= R_WR;
          end else if (ring_end) begin
            state_q <= S_FIN;
          end else begin
            ring_q <= ring_q + 1'b1;
          end
        end

        R_WR: begin
          r_vld_q[ring_q]     <= 1'b1;
          pend_mask_q[ring_q] <= 1'b0;
          if (ring_end) begin
            state_q <= S_FIN;
          end else begin
            ring_q  <= ring_q + 1'b1;
            state_q <= R_CHK;
          end
        end

        // Final result of the request, marked last.
        S_FIN: begin
          if (out_free) begin
            out_last_q <= 1'b1;
            if (hold_vld_q) begin
              out_ring_q  <= hold_ring_q;
              out_start_q <= hold_start_q;
              out_len_q   <= hold_len_q;
              out_total_q <= hold_total_q;
            end else begin
              out_ring_q  <= fin_ring_q;
              out_start_q <= '0;
              out_len_q   <= '0;
              out_total_q <= acc_q;
            end
            hold_vld_q <= 1'b0;
            state_q    <= S_IDLE;
          end
        end

        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o   = out_vld_q;
  assign ring_index_o  = out_ring_q;
  assign seg_start_o   = out_start_q;
  assign seg_len_o     = out_len_q;
  assign total_count_o = out_total_q;
  assign last_o        = out_last_q;

endmodule
